// ----- src/lskt_pkg.sv -----
// shared types and codes for the lazy sorted key table
package lskt_pkg;
	typedef enum logic [1:0] {
		CMD_PUSH = 2'd0,
		CMD_POP  = 2'd1,
		CMD_FIND = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;
	localparam int IN_BITS  = 34;
	localparam int IN_BYTES = 5;
	localparam int OUT_BITS = 47;
	localparam int OUT_BYTES = 6;
endpackage

// ----- src/lazy_sorted_key_table_core.sv -----
// lazy sorted key table: key store with on-demand insertion sort and binary search
//
// A request is accepted in S_IDLE and answered from S_DONE. Push goes to S_DONE,
// or through S_PUSHRD and S_PUSHCMP when the table is marked sorted and holds keys,
// since the previous last key is then read back and compared. Pop uses S_POPRD and
// S_POPWT. Find on an unsorted table first runs an insertion sort through the key
// memory, in S_SORTI, S_SORTRV, S_SORTRP and S_SORTCMP per entry plus S_SORTRP and
// S_SORTCMP per shifted entry (quadratic in the count), then bisects through
// S_PROBE, S_PRWT and S_PRCMP per probe, log2(DEPTH)+1 probes at most. The memory
// has one read and one write port with registered read data; the comparator is
// shared. The block takes no request while one is in progress; a finished result
// sits in the output register while the block idles. A configuration write offered
// with a request goes first. No clearing pass follows reset.
module lazy_sorted_key_table_core #(
	parameter int DEPTH     = 64,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,       // order_mode
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,        // cmd[1:0], key[33:2], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata         // status[1:0], key_out[33:2], position[39:34],
	                                    // entry_total[46:40], zero fill
);
	import lskt_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_PUSHRD, S_PUSHCMP, S_POPRD, S_POPWT, S_SORTI, S_SORTRV, S_SORTRP,
		S_SORTCMP, S_PROBE, S_PRWT, S_PRCMP, S_DONE
	} state_t;

	state_t state_q;
	logic [KEY_WIDTH-1:0] mem [DEPTH];
	logic [KEY_WIDTH-1:0] rd_q, key_q, v_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic [AW-1:0] wr_addr;
	logic [KEY_WIDTH-1:0] wr_data;
	logic wr_en;
	logic [CW-1:0] count_q, i_q, j_q, low_q, high_q, mid_q;
	logic sorted_q, order_q;
	logic [1:0] st_q;
	logic [31:0] kout_q;
	logic [5:0] pos_q;

	// shared comparator: a orders after b, a orders before b
	logic [KEY_WIDTH-1:0] ca, cb;
	logic c_gt, c_lt, gt_raw, lt_raw;
	assign gt_raw = ca > cb;
	assign lt_raw = ca < cb;
	assign c_gt = order_q ? lt_raw : gt_raw;
	assign c_lt = order_q ? gt_raw : lt_raw;

	logic [KEY_WIDTH-1:0] in_key;
	logic [31:0] in_key32;
	assign in_key32 = s_tdata[33:2];
	assign in_key = KEY_WIDTH'(in_key32);

	logic [CW-1:0] mid_c;
	assign mid_c = low_q + ((high_q - low_q) >> 1);

	always_comb begin
		ca = key_q;
		cb = rd_q;
		case (state_q)
			S_SORTCMP: begin ca = rd_q;   cb = v_q;    end
			default:   begin ca = key_q;  cb = rd_q;   end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	logic [31:0] rd32;
	assign rd32 = 32'(rd_q);

	assign s_tready = (state_q == S_IDLE) && !m_tvalid && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) && !m_tvalid;
	assign m_tdata = {1'b0, 7'(count_q), pos_q, kout_q, st_q};

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = v_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tready && cmd_t'(s_tdata[1:0]) == CMD_PUSH
					&& count_q < CW'(DEPTH)) begin
					wr_en = 1'b1;
					wr_addr = count_q[AW-1:0];
					wr_data = in_key;
				end
			end
			S_PUSHRD: begin rd_en = 1'b1; rd_addr = AW'(count_q - 2'd2); end
			S_POPRD: begin rd_en = 1'b1; rd_addr = count_q[AW-1:0]; end
			S_SORTI: begin rd_en = 1'b1; rd_addr = i_q[AW-1:0]; end
			S_SORTRP: begin rd_en = 1'b1; rd_addr = AW'(j_q - 1'b1); end
			S_SORTCMP: begin
				wr_en = 1'b1;
				wr_addr = j_q[AW-1:0];
				wr_data = (j_q != 0 && c_gt) ? rd_q : v_q;
			end
			S_PROBE: begin rd_en = 1'b1; rd_addr = mid_c[AW-1:0]; end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sorted_q <= 1'b0;
			order_q <= 1'b0;
			m_tvalid <= 1'b0;
			key_q <= '0;
			v_q <= '0;
			st_q <= ST_OK;
			kout_q <= '0;
			pos_q <= '0;
			i_q <= '0;
			j_q <= '0;
			low_q <= '0;
			high_q <= '0;
			mid_q <= '0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						order_q <= cfg_data;
						sorted_q <= 1'b0;
					end else if (s_tvalid && s_tready) begin
						key_q <= in_key;
						st_q <= ST_OK;
						kout_q <= '0;
						pos_q <= '0;
						case (cmd_t'(s_tdata[1:0]))
							CMD_PUSH: begin
								if (count_q >= CW'(DEPTH)) begin
									st_q <= ST_FULL;
									state_q <= S_DONE;
								end else begin
									count_q <= count_q + 1'b1;
									if (sorted_q && count_q != 0) state_q <= S_PUSHRD;
									else state_q <= S_DONE;
								end
							end
							CMD_POP: begin
								if (count_q == 0) begin
									st_q <= ST_EMPTY;
									state_q <= S_DONE;
								end else begin
									count_q <= count_q - 1'b1;
									state_q <= S_POPRD;
								end
							end
							CMD_FIND: begin
								st_q <= ST_NOT_FOUND;
								low_q <= '0;
								high_q <= count_q;
								if (count_q == 0) state_q <= S_DONE;
								else if (sorted_q) state_q <= S_PROBE;
								else begin
									i_q <= CW'(1);
									state_q <= S_SORTI;
								end
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_PUSHRD: state_q <= S_PUSHCMP;
				S_PUSHCMP: begin
					// previous last key orders after the new one
					if (c_lt) sorted_q <= 1'b0;
					state_q <= S_DONE;
				end
				S_POPRD: state_q <= S_POPWT;
				S_POPWT: begin
					kout_q <= rd32;
					state_q <= S_DONE;
				end
				S_SORTI: begin
					if (i_q >= count_q) begin
						sorted_q <= 1'b1;
						state_q <= S_PROBE;
					end else begin
						j_q <= i_q;
						state_q <= S_SORTRV;
					end
				end
				S_SORTRV: begin
					v_q <= rd_q;
					state_q <= S_SORTRP;
				end
				S_SORTRP: state_q <= S_SORTCMP;
				S_SORTCMP: begin
					if (j_q != 0 && c_gt) begin
						j_q <= j_q - 1'b1;
						state_q <= S_SORTRP;
					end else begin
						i_q <= i_q + 1'b1;
						state_q <= S_SORTI;
					end
				end
				S_PROBE: begin
					if (high_q > low_q) begin
						mid_q <= mid_c;
						state_q <= S_PRWT;
					end else state_q <= S_DONE;
				end
				S_PRWT: state_q <= S_PRCMP;
				S_PRCMP: begin
					if (c_gt) begin
						low_q <= mid_q + 1'b1;
						state_q <= S_PROBE;
					end else if (c_lt) begin
						high_q <= mid_q;
						state_q <= S_PROBE;
					end else begin
						st_q <= ST_OK;
						kout_q <= rd32;
						pos_q <= 6'(mid_q);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					m_tvalid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- verif/tb_lazy_sorted_key_table_core.sv -----
// testbench for the lazy sorted key table: random and directed requests checked against a predictor
class key_table_scoreboard;
	logic [47:0] pending[$];
	int errors;
	logic [31:0] keys[64];
	int unsigned count;
	bit sorted;
	bit descending;

	function new();
		errors = 0;
		count = 0;
		sorted = 0;
		descending = 0;
	endfunction

	function void set_order(bit d);
		descending = d;
		sorted = 0;
	endfunction

	function int order_cmp(logic [31:0] a, logic [31:0] b);
		int r;
		r = (a > b) ? 1 : ((a < b) ? -1 : 0);
		return descending ? -r : r;
	endfunction

	function void sort_keys();
		int i;
		int j;
		logic [31:0] v;
		if (count == 0 || sorted)
			return;
		for (i = 1; i < count; i++) begin
			v = keys[i];
			j = i;
			while (j > 0 && order_cmp(keys[j-1], v) > 0) begin
				keys[j] = keys[j-1];
				j--;
			end
			keys[j] = v;
		end
		sorted = 1;
	endfunction

	function void note_request(lskt_pkg::cmd_t cmd, logic [31:0] key);
		lskt_pkg::status_t st;
		logic [31:0] kout;
		logic [5:0] pos;
		int lo;
		int hi;
		int mid;
		int c;
		st = lskt_pkg::ST_OK;
		kout = 0;
		pos = 0;
		case (cmd)
			lskt_pkg::CMD_PUSH: begin
				if (count >= 64) st = lskt_pkg::ST_FULL;
				else begin
					keys[count] = key;
					if (sorted && count > 0 && order_cmp(keys[count-1], key) > 0)
						sorted = 0;
					count++;
				end
			end
			lskt_pkg::CMD_POP: begin
				if (count == 0) st = lskt_pkg::ST_EMPTY;
				else begin
					count--;
					kout = keys[count];
				end
			end
			lskt_pkg::CMD_FIND: begin
				st = lskt_pkg::ST_NOT_FOUND;
				if (count > 0) begin
					sort_keys();
					lo = 0;
					hi = count;
					while (hi > lo) begin
						mid = lo + (hi - lo) / 2;
						c = order_cmp(key, keys[mid]);
						if (c > 0) lo = mid + 1;
						else if (c < 0) hi = mid;
						else begin
							st = lskt_pkg::ST_OK;
							kout = keys[mid];
							pos = mid[5:0];
							break;
						end
					end
				end
			end
			default: ;
		endcase
		pending.push_back({1'b0, 7'(count), pos, kout, 2'(st)});
	endfunction

	function void check_result(logic [47:0] got);
		logic [47:0] exp;
		if (pending.size() == 0) begin
			report("result with none expected", got, 48'd0);
			return;
		end
		exp = pending.pop_front();
		if (got[1:0] !== exp[1:0]) report("status", got, exp);
		if (got[33:2] !== exp[33:2]) report("key_out", got, exp);
		if (got[39:34] !== exp[39:34]) report("position", got, exp);
		if (got[46:40] !== exp[46:40]) report("entry_total", got, exp);
	endfunction

	function void report(string what, logic [47:0] got, logic [47:0] exp);
		errors++;
		if (errors <= 50)
			$display("mismatch %s: got %h expected %h", what, got, exp);
	endfunction
endclass

module tb_lazy_sorted_key_table_core;
	import lskt_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [39:0] s_tdata = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [47:0] m_tdata;

	key_table_scoreboard sb = new();
	int send_idle;
	int recv_stall;
	longint cycles = 0;
	logic [31:0] pool[8];

	lazy_sorted_key_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 30000000) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_stall);
	end

	task automatic send_request(cmd_t cmd, logic [31:0] key);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {6'd0, key, cmd};
		do @(posedge clk); while (!s_tready);
		sb.note_request(cmd, key);
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (sb.pending.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_order(bit d);
		drain();
		cfg_valid <= 1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_order(d);
		cfg_valid <= 0;
	endtask

	function automatic logic [31:0] pick_key();
		case ($urandom_range(3))
			0: return pool[$urandom_range(7)];
			1: return $urandom_range(15);
			2: return 32'hFFFFFFFF - $urandom_range(3);
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int n);
		int k;
		int r;
		cmd_t c;
		for (k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 2) c = CMD_NONE;
			else if (r < 50) c = CMD_PUSH;
			else if (r < 70) c = CMD_POP;
			else c = CMD_FIND;
			if (c == CMD_FIND && sb.count > 0 && $urandom_range(1))
				send_request(c, sb.keys[$urandom_range(sb.count - 1)]);
			else
				send_request(c, pick_key());
		end
	endtask

	initial begin
		int i;
		int ph;
		for (i = 0; i < 8; i++) pool[i] = $urandom;
		send_idle = 0;
		recv_stall = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed
		send_request(CMD_POP, 32'hFFFFFFFF);
		send_request(CMD_FIND, 32'd0);
		send_request(CMD_NONE, 32'hFFFFFFFF);
		send_request(CMD_PUSH, 32'hFFFFFFFF);
		send_request(CMD_PUSH, 32'd0);
		send_request(CMD_PUSH, 32'd5);
		send_request(CMD_PUSH, 32'd5);
		send_request(CMD_FIND, 32'd5);
		send_request(CMD_FIND, 32'hFFFFFFFF);
		send_request(CMD_FIND, 32'd7);
		send_request(CMD_POP, 32'd0);
		write_order(1);
		send_request(CMD_FIND, 32'd0);
		send_request(CMD_PUSH, 32'h80000000);
		send_request(CMD_FIND, 32'h80000000);
		for (i = 0; i < 62; i++) send_request(CMD_PUSH, $urandom);
		send_request(CMD_PUSH, 32'h12345678);
		send_request(CMD_FIND, sb.keys[10]);
		send_request(CMD_NONE, 32'd0);
		for (i = 0; i < 65; i++) send_request(CMD_POP, 32'd0);
		write_order(0);
		// random phases
		for (ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 70; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 70; end
				default: begin send_idle = 7; recv_stall = 7; end
			endcase
			random_phase(200);
			write_order(ph % 2);
		end
		write_order(0);
		drain();
		if (sb.errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
